### design/ray_sphere_pixel_shader_unit_defines.svh
// Assertion macros used by the top-level design file
`ifndef RAY_SPHERE_PIXEL_SHADER_UNIT_DEFINES_SVH
`define RAY_SPHERE_PIXEL_SHADER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RSPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RSPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RSPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### design/rsps_pkg.sv
package rsps_pkg;

    localparam logic       REG_CAMERA_Y    = 1'b0;
    localparam logic       REG_RADIUS_LOG2 = 1'b1;
    localparam logic signed [11:0] CAMERA_Y_RST = -12'sd200;
    localparam logic [2:0] RADIUS_LOG2_RST = 3'd5;
    localparam logic [7:0] SKY_COLOR       = 8'd155;
    localparam logic [4:0] CH_SHIFT        = 5'd7;
    localparam int         SQRT_BITS       = 15;
    localparam int         DIV_BITS        = 16;

    typedef struct packed {
        logic signed [11:0] cy;
        logic [2:0]         k;
        logic [4:0]         sf;
    } t_cfg;

    typedef struct packed {
        logic [12:0]       addr;
        logic signed [8:0] dx;
        logic signed [8:0] dz;
    } t_pix;

    typedef struct packed {
        t_pix               pix;
        logic signed [20:0] hb;
        logic [17:0]        qa;
        logic signed [43:0] disc;
        logic [14:0]        res;
        logic [31:0]        sq;
    } t_sq;

    typedef struct packed {
        t_pix        pix;
        logic        pos;
        logic        neg;
        logic [17:0] den;
        logic [32:0] scaled;
        logic [15:0] res;
        logic [35:0] prod;
    } t_dv;

    typedef struct packed {
        t_pix        pix;
        logic        hit;
        logic [15:0] t;
    } t_sh;

    function automatic logic [7:0] shade_ch(input logic signed [25:0] n,
                                            input logic [4:0] sf);
        logic signed [31:0] v;
        logic [31:0]        m;
        v = 32'(n) + (32'sd1 <<< sf);
        if (v < 0) begin
            m = 32'd0;
        end else if (sf >= CH_SHIFT) begin
            m = $unsigned(v) >> (sf - CH_SHIFT);
        end else begin
            m = $unsigned(v) << (CH_SHIFT - sf);
        end
        return (m > 32'd255) ? 8'hFF : m[7:0];
    endfunction

endpackage

### design/rsps_front.sv
module rsps_front #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 60
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  rsps_pkg::t_cfg   i_cfg,
    input  logic             i_vld,
    input  logic [6:0]       i_col,
    input  logic [5:0]       i_row,
    output logic             o_vld,
    output rsps_pkg::t_sq    o_data
);

    logic [3:0] r_vld;
    rsps_pkg::t_pix r_p1, r_p2, r_p3, n_p1;
    logic [17:0]        r_qa2, r_qa3, n_qa;
    logic signed [20:0] r_hb2, r_hb3, n_hb;
    logic signed [24:0] r_qc2, n_qc;
    logic signed [41:0] r_hbsq, n_hbsq;
    logic signed [42:0] r_aqc, n_aqc;
    logic signed [17:0] sx, sz;
    logic signed [43:0] n_disc;
    rsps_pkg::t_sq r_out, n_out;

    always_comb begin
        n_p1.addr = {i_row, i_col};
        n_p1.dx   = $signed({2'b00, i_col}) - $signed(9'(SCREEN_COLS >> 1));
        n_p1.dz   = $signed(9'(SCREEN_ROWS - 1)) - $signed({3'b000, i_row})
                    - $signed(9'(SCREEN_ROWS >> 1));
        sx     = r_p1.dx * r_p1.dx;
        sz     = r_p1.dz * r_p1.dz;
        n_qa   = 18'(sx) + 18'(sz) + 18'(SCREEN_COLS * SCREEN_COLS);
        n_hb   = i_cfg.cy * $signed(21'(SCREEN_COLS));
        n_qc   = i_cfg.cy * i_cfg.cy - $signed(25'(1) << {i_cfg.k, 1'b0});
        n_hbsq = r_hb2 * r_hb2;
        n_aqc  = $signed({1'b0, r_qa2}) * r_qc2;
        n_disc = r_hbsq - r_aqc;
        n_out.pix  = r_p3;
        n_out.hb   = r_hb3;
        n_out.qa   = r_qa3;
        n_out.disc = n_disc;
        n_out.res  = '0;
        n_out.sq   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= n_p1;
            r_p2   <= r_p1;
            r_qa2  <= n_qa;
            r_hb2  <= n_hb;
            r_qc2  <= n_qc;
            r_p3   <= r_p2;
            r_qa3  <= r_qa2;
            r_hb3  <= r_hb2;
            r_hbsq <= n_hbsq;
            r_aqc  <= n_aqc;
            r_out  <= n_out;
        end
    end

    assign o_vld  = r_vld[3];
    assign o_data = r_out;

endmodule

### design/rsps_sqrt.sv
module rsps_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  rsps_pkg::t_sq i_data,
    output logic          o_vld,
    output rsps_pkg::t_sq o_data
);

    localparam int N = rsps_pkg::SQRT_BITS;

    logic          r_vld [N];
    rsps_pkg::t_sq r_st  [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam int B = N - 1 - i;
        logic          in_vld;
        rsps_pkg::t_sq in_st, n_st;
        logic [31:0]   cand_sq;

        if (i == 0) begin : g_first
            assign in_vld = i_vld;
            assign in_st  = i_data;
        end else begin : g_next
            assign in_vld = r_vld[i-1];
            assign in_st  = r_st[i-1];
        end

        always_comb begin
            cand_sq = in_st.sq + (32'(in_st.res) << (B + 1)) + (32'd1 << (2 * B));
            n_st    = in_st;
            if (in_st.disc >= $signed({12'd0, cand_sq})) begin
                n_st.res[B] = 1'b1;
                n_st.sq     = cand_sq;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[i] <= n_st;
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_data = r_st[N-1];

endmodule

### design/rsps_div.sv
module rsps_div #(
    parameter int T_FRACTION_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  rsps_pkg::t_sq i_data,
    output logic          o_vld,
    output rsps_pkg::t_sh o_data
);

    localparam int N = rsps_pkg::DIV_BITS;

    logic               r_vld [N+1];
    rsps_pkg::t_dv      r_st  [N+1];
    logic signed [21:0] num;
    logic [21:0]        mag;
    rsps_pkg::t_dv      n_prep;

    always_comb begin
        num           = -22'(i_data.hb) - $signed({7'd0, i_data.res});
        mag           = num[21] ? 22'(-num) : 22'(num);
        n_prep.pix    = i_data.pix;
        n_prep.pos    = i_data.disc > 44'sd0;
        n_prep.neg    = num[21];
        n_prep.den    = i_data.qa;
        n_prep.scaled = 33'(mag) << T_FRACTION_BITS;
        n_prep.res    = '0;
        n_prep.prod   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_prep;
        end
    end

    for (genvar i = 1; i <= N; i++) begin : g_stage
        localparam int B = N - i;
        rsps_pkg::t_dv n_st;
        logic [35:0]   cand;

        always_comb begin
            cand = r_st[i-1].prod + (36'(r_st[i-1].den) << B);
            n_st = r_st[i-1];
            if (cand <= 36'(r_st[i-1].scaled)) begin
                n_st.res[B] = 1'b1;
                n_st.prod   = cand;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= r_vld[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[i] <= n_st;
            end
        end
    end

    assign o_vld      = r_vld[N];
    assign o_data.pix = r_st[N].pix;
    assign o_data.hit = r_st[N].pos && !r_st[N].neg && (r_st[N].res != '0);
    assign o_data.t   = r_st[N].res;

endmodule

### design/rsps_shade.sv
module rsps_shade #(
    parameter int SCREEN_COLS     = 80,
    parameter int T_FRACTION_BITS = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  rsps_pkg::t_cfg i_cfg,
    input  logic           i_vld,
    input  rsps_pkg::t_sh  i_data,
    output logic           o_vld,
    output logic [12:0]    o_addr,
    output logic [7:0]     o_color,
    output logic           o_hit
);

    logic               r_vld1, r_vld2;
    logic [12:0]        r_addr1, r_addr2;
    logic               r_hit1, r_hit2;
    logic signed [25:0] r_nx, r_ny, r_nz, n_nx, n_ny, n_nz, cy_s;
    logic signed [16:0] t_s;
    logic [7:0]         cr, cg, cb, r_color, n_color;

    always_comb begin
        t_s  = $signed({1'b0, i_data.t});
        cy_s = 26'(i_cfg.cy);
        n_nx = i_data.pix.dx * t_s;
        n_nz = i_data.pix.dz * t_s;
        n_ny = (cy_s <<< T_FRACTION_BITS) + $signed(26'(SCREEN_COLS)) * t_s;
        cr   = rsps_pkg::shade_ch(r_nx, i_cfg.sf);
        cg   = rsps_pkg::shade_ch(r_nz, i_cfg.sf);
        cb   = rsps_pkg::shade_ch(r_ny, i_cfg.sf);
        if (r_hit1) begin
            n_color = (cr & 8'hE0) | {3'b000, cg[7:5], 2'b00} | {6'd0, cb[7:6]};
        end else begin
            n_color = rsps_pkg::SKY_COLOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_addr1 <= i_data.pix.addr;
            r_hit1  <= i_data.hit;
            r_nx    <= n_nx;
            r_ny    <= n_ny;
            r_nz    <= n_nz;
            r_addr2 <= r_addr1;
            r_hit2  <= r_hit1;
            r_color <= n_color;
        end
    end

    assign o_vld   = r_vld2;
    assign o_addr  = r_addr2;
    assign o_color = r_color;
    assign o_hit   = r_hit2;

endmodule

### design/ray_sphere_pixel_shader_unit.sv
// Ray-sphere pixel shader.
// Slave stream: one pixel per transfer, tdata = {row, column}.
// Master stream: one result per pixel, tdata = {color, pixel_address},
// tuser = hit. Results leave in input order.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_addr
// (0: camera_y, 1: radius_log2); write only while the pipeline is empty.
// Pipeline: 38 register stages (4 setup, 15 square-root, 17 divide, 2 shade).
// Throughput: one pixel per cycle while the output is not stalled; every
// stage is a register so a new pixel may enter each clock that tready is high.
// Reset (synchronous, active low): all stage valids clear, camera_y = -200,
// radius_log2 = 5.
// Stall: when the output holds a result that is not taken, the whole
// pipeline freezes and o_s_axis_tready drops; nothing is lost or repeated.
`include "ray_sphere_pixel_shader_unit_defines.svh"
module ray_sphere_pixel_shader_unit #(
    parameter int SCREEN_COLS     = 80,
    parameter int SCREEN_ROWS     = 60,
    parameter int T_FRACTION_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // column[6:0], row[12:7]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // pixel_address[12:0], color[20:13]
    output logic [0:0]  o_m_axis_tuser,   // hit[0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [11:0] i_cfg_data
);

    logic signed [11:0] r_cy;
    logic [2:0]         r_k;
    rsps_pkg::t_cfg     cfg;
    logic               en;
    logic               fr_vld, sq_vld, dv_vld;
    rsps_pkg::t_sq      fr_data, sq_data;
    rsps_pkg::t_sh      dv_data;
    logic [12:0]        addr;
    logic [7:0]         color;
    logic               hit;
    logic               m_stall;
    logic               cam_we;
    logic               sky_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cy <= rsps_pkg::CAMERA_Y_RST;
            r_k  <= rsps_pkg::RADIUS_LOG2_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rsps_pkg::REG_CAMERA_Y:    r_cy <= $signed(i_cfg_data);
                rsps_pkg::REG_RADIUS_LOG2: r_k  <= i_cfg_data[2:0];
                default:                   r_k  <= r_k;
            endcase
        end
    end

    assign cfg.cy = r_cy;
    assign cfg.k  = r_k;
    assign cfg.sf = 5'(r_k) + 5'(T_FRACTION_BITS);

    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    rsps_front #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_cfg  (cfg),
        .i_vld  (i_s_axis_tvalid),
        .i_col  (i_s_axis_tdata[6:0]),
        .i_row  (i_s_axis_tdata[12:7]),
        .o_vld  (fr_vld),
        .o_data (fr_data)
    );

    rsps_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (fr_vld),
        .i_data (fr_data),
        .o_vld  (sq_vld),
        .o_data (sq_data)
    );

    rsps_div #(
        .T_FRACTION_BITS(T_FRACTION_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (sq_vld),
        .i_data (sq_data),
        .o_vld  (dv_vld),
        .o_data (dv_data)
    );

    rsps_shade #(
        .SCREEN_COLS    (SCREEN_COLS),
        .T_FRACTION_BITS(T_FRACTION_BITS)
    ) u_shade (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_cfg  (cfg),
        .i_vld  (dv_vld),
        .i_data (dv_data),
        .o_vld  (o_m_axis_tvalid),
        .o_addr (addr),
        .o_color(color),
        .o_hit  (hit)
    );

    assign o_m_axis_tdata = {3'b000, color, addr};
    assign o_m_axis_tuser = hit;

    assign m_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign cam_we  = i_cfg_we && (i_cfg_addr == rsps_pkg::REG_CAMERA_Y);
    assign sky_out = o_m_axis_tvalid && !hit;

    `RSPS_ASSERT_IMPL(a_stall_backpressure, i_clk, i_rst_n, m_stall, !o_s_axis_tready)
    `RSPS_ASSERT_NEXT(a_cfg_cam_write, i_clk, i_rst_n, cam_we, r_cy == $signed($past(i_cfg_data)))
    `RSPS_ASSERT_IMPL(a_miss_is_sky, i_clk, i_rst_n, sky_out, color == rsps_pkg::SKY_COLOR)

endmodule

### tb/tb_ray_sphere_pixel_shader_unit.sv
module tb_ray_sphere_pixel_shader_unit;
    import rsps_pkg::*;

    typedef struct {
        logic [12:0] addr;
        logic [7:0]  color;
        logic        hit;
    } pix_out_t;

    typedef struct {
        int   cy;
        int   k;
        int   col;
        int   row;
        bit   known;
        int   color;
        bit   hit;
    } dir_row_t;

    localparam int N_RANDOM    = 1640;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [11:0] i_cfg_data;

    ray_sphere_pixel_shader_unit dut (.*);

    logic signed [11:0] cam_y;
    logic [2:0]         rad_log2;
    pix_out_t           pending_px[$];
    int                 n_errors;
    int                 n_sent;
    int                 n_checked;
    int                 n_hits;
    int                 cycles;
    bit                 quiet;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, pending_px.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint shade_ch_model(longint n, int sf);
        longint v;
        longint ch;
        int     s;
        v = n + (longint'(1) <<< sf);
        if (sf >= 7) begin
            s = sf - 7;
            if (v >= 0) ch = v >>> s;
            else ch = -(((-v) + ((longint'(1) <<< s) - 1)) >>> s);
        end else begin
            ch = v * (longint'(1) <<< (7 - sf));
        end
        if (ch < 0) ch = 0;
        if (ch > 255) ch = 255;
        return ch;
    endfunction

    function automatic pix_out_t shade_pixel(int col, int row, logic signed [11:0] cy,
                                             logic [2:0] k);
        pix_out_t o;
        longint dx, dy, dz, qa, hb, qc, disc, cyl, rad;
        longint s, step, num, mag, scaled, t, nx, ny, nz;
        longint cr, cg, cb;
        bit     neg;
        cyl = cy;
        rad = longint'(1) <<< k;
        dx = col - 40;
        dy = 80;
        dz = (59 - row) - 30;
        qa = dx * dx + dy * dy + dz * dz;
        hb = cyl * dy;
        qc = cyl * cyl - rad * rad;
        disc = hb * hb - qa * qc;
        t = -1;
        if (disc > 0) begin
            s = 0;
            for (step = 16384; step > 0; step = step >>> 1)
                if ((s + step) * (s + step) <= disc) s = s + step;
            num = -hb - s;
            neg = num < 0;
            mag = neg ? -num : num;
            scaled = mag <<< 10;
            t = 0;
            for (step = 32768; step > 0; step = step >>> 1)
                if (qa * (t + step) <= scaled) t = t + step;
            if (neg) t = -t;
        end
        o.addr = 13'(row * 128 + col);
        if (t <= 0) begin
            o.color = SKY_COLOR;
            o.hit = 1'b0;
        end else begin
            nx = dx * t;
            ny = cyl * 1024 + dy * t;
            nz = dz * t;
            cr = shade_ch_model(nx, k + 10);
            cg = shade_ch_model(nz, k + 10);
            cb = shade_ch_model(ny, k + 10);
            o.color = 8'((cr & 'hE0) | ((cg >> 5) << 2) | (cb >> 6));
            o.hit = 1'b1;
        end
        return o;
    endfunction

    // output side: random stalls, none in the tail
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 12);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        pix_out_t e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected transfer addr=%0d color=%0d hit=%0d", $time,
                         o_m_axis_tdata[12:0], o_m_axis_tdata[20:13], o_m_axis_tuser[0]);
                n_errors++;
            end else begin
                e = pending_px.pop_front();
                n_checked++;
                if (e.hit) n_hits++;
                if (o_m_axis_tdata[12:0] !== e.addr) begin
                    $display("%0t: addr expected %0d actual %0d", $time, e.addr,
                             o_m_axis_tdata[12:0]);
                    n_errors++;
                end
                if (o_m_axis_tdata[20:13] !== e.color) begin
                    $display("%0t: color (addr %0d) expected %0d actual %0d", $time, e.addr,
                             e.color, o_m_axis_tdata[20:13]);
                    n_errors++;
                end
                if (o_m_axis_tuser[0] !== e.hit) begin
                    $display("%0t: hit (addr %0d) expected %0d actual %0d", $time, e.addr,
                             e.hit, o_m_axis_tuser[0]);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_pixel(int col, int row, bit known, int color, bit hit);
        pix_out_t e;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b000, 6'(row), 7'(col)};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (known) begin
            e.addr = 13'(row * 128 + col);
            e.color = 8'(color);
            e.hit = hit;
        end else begin
            e = shade_pixel(col, row, cam_y, rad_log2);
        end
        pending_px.push_back(e);
        n_sent++;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_cfg(int cy, int k);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_CAMERA_Y;
        i_cfg_data <= 12'(cy);
        @(posedge i_clk);
        i_cfg_addr <= REG_RADIUS_LOG2;
        i_cfg_data <= 12'(k);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cam_y = 12'(cy);
        rad_log2 = 3'(k);
    endtask

    dir_row_t dir_rows[] = '{
        '{-200, 5,   0,  0, 1, 155, 0},
        '{-200, 5, 127, 63, 1, 155, 0},
        '{-200, 5,  40, 29, 0,   0, 0},
        '{-200, 5,  41, 28, 0,   0, 0},
        '{-200, 5,  79, 59, 0,   0, 0},
        '{2047, 7,  40, 29, 1, 155, 0},
        '{2047, 7,   0,  0, 1, 155, 0},
        '{-2048, 7, 40, 29, 0,   0, 0},
        '{-2048, 7, 39, 30, 0,   0, 0},
        '{-1,   0,  40, 29, 1, 155, 0},
        '{-1,   0, 127,  0, 1, 155, 0},
        '{-1,   7,  40, 29, 1, 155, 0},
        '{-1,   7,   0, 63, 1, 155, 0},
        '{-300, 6,  40, 29, 0,   0, 0},
        '{-300, 6,  45, 25, 0,   0, 0},
        '{-300, 6,  50, 40, 0,   0, 0},
        '{-40,  4, 120, 62, 0,   0, 0}
    };

    initial begin
        int cy, k, col, row, span;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_CAMERA_Y;
        i_cfg_data = '0;
        cam_y = CAMERA_Y_RST;
        rad_log2 = RADIUS_LOG2_RST;
        quiet = 1'b0;
        stall_left = 0;
        cycles = 0;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_hits = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cy != int'(cam_y) || dir_rows[i].k != int'(rad_log2)) begin
                drain();
                write_cfg(dir_rows[i].cy, dir_rows[i].k);
            end
            send_pixel(dir_rows[i].col, dir_rows[i].row, dir_rows[i].known,
                       dir_rows[i].color, dir_rows[i].hit);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 120 == 0) begin
                drain();
                case ($urandom_range(0, 5))
                    0: cy = -2048;
                    1: cy = -1;
                    2: cy = $urandom_range(0, 2047);
                    default: cy = -int'($urandom_range(20, 400));
                endcase
                k = $urandom_range(0, 7);
                write_cfg(cy, k);
            end
            if (i >= N_RANDOM - QUIET_TAIL) quiet = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                col = $urandom_range(0, 127);
                row = $urandom_range(0, 63);
            end else if ($urandom_range(0, 1) == 0) begin
                // aim near screen center where the sphere sits
                span = $urandom_range(2, 20);
                col = 40 + $urandom_range(0, 2 * span) - span;
                row = 29 + $urandom_range(0, 2 * span) - span;
            end else begin
                col = $urandom_range(0, 79);
                row = $urandom_range(0, 59);
            end
            send_pixel(col, row, 1'b0, 0, 1'b0);
        end
        drain();

        $display("%0d pixels sent, %0d results checked, %0d sphere hits", n_sent,
                 n_checked, n_hits);
        $display("camera and radius swept across extremes, off-image pixels included");
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/rsps_pkg.sv
design/rsps_front.sv
design/rsps_sqrt.sv
design/rsps_div.sv
design/rsps_shade.sv
design/ray_sphere_pixel_shader_unit.sv
tb/tb_ray_sphere_pixel_shader_unit.sv
